// File: rtl/kbt_pkg.sv
// Shared types, widths and constants of the box center Kalman tracker.
`default_nettype none

package kbt_pkg;

    // Field widths.
    localparam int PIX_W     = 12;
    localparam int DATA_W    = 32;
    localparam int NOISE_W   = 31;
    localparam int CFG_IDX_W = 8;

    // Datapath widths: the accumulator holds a few Q8.24 products before saturation.
    localparam int ACC_W     = 48;
    localparam int OPD_W     = 33;
    localparam int PROD_W    = 2 * OPD_W;
    localparam int Q_SHIFT   = 24;
    localparam int QUOT_W    = 31;

    // Memory geometry: the state memory holds the estimate and then the covariance,
    // the work memory holds the predicted covariance and then the gain.
    localparam int MEM_AW    = 5;
    localparam int ST_DEPTH  = 20;
    localparam int WK_DEPTH  = 24;

    localparam logic signed [DATA_W-1:0] ONE_Q24 = 32'sd16777216;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = 8'd3;

    // Register reset values.
    localparam logic [NOISE_W-1:0]       PROCESS_NOISE_RST = 31'd1678;
    localparam logic [NOISE_W-1:0]       MEASURE_NOISE_RST = 31'd167772;
    localparam logic signed [DATA_W-1:0] START_RST         = 32'sd6553600;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_PP,
        ST_SINV,
        ST_DET,
        ST_GAIN,
        ST_DIV,
        ST_EST,
        ST_COV,
        ST_OUT
    } kbt_state_t;

    // Operand sources of the shared multiply-accumulate unit.
    typedef enum logic [3:0] {
        SRC_RD,
        SRC_OPA,
        SRC_ONE,
        SRC_Q,
        SRC_R,
        SRC_S00,
        SRC_S01,
        SRC_S10,
        SRC_S11,
        SRC_NS01,
        SRC_NS10,
        SRC_Y0,
        SRC_Y1,
        SRC_XH
    } kbt_src_t;

    localparam int SRC_NUM = 14;

    // Micro operations.
    typedef enum logic [1:0] {
        OP_NOP,
        OP_LOAD,
        OP_ADD,
        OP_SUB
    } kbt_op_t;

    typedef struct packed {
        logic              wmem;
        logic [MEM_AW-1:0] addr;
        kbt_src_t          sa;
        kbt_src_t          sb;
        kbt_op_t           op;
    } kbt_uop_t;

    // Divider request and response.
    typedef struct packed {
        logic                     start;
        logic signed [ACC_W-1:0]  num;
        logic signed [ACC_W-1:0]  den;
    } kbt_div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quot;
    } kbt_div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/kbt_ifs.sv
// Handshake interfaces of the tracker: box input, box output and configuration write.
`default_nettype none

interface kbt_in_if import kbt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] corner_a_x;
    logic [PIX_W-1:0] corner_a_y;
    logic [PIX_W-1:0] corner_b_x;
    logic [PIX_W-1:0] corner_b_y;

    modport source (output valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                    input ready);
    modport sink   (input valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                    output ready);
endinterface

interface kbt_out_if import kbt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_a_x;
    logic signed [DATA_W-1:0] out_a_y;
    logic signed [DATA_W-1:0] out_b_x;
    logic signed [DATA_W-1:0] out_b_y;

    modport source (output valid, out_a_x, out_a_y, out_b_x, out_b_y, input ready);
    modport sink   (input valid, out_a_x, out_a_y, out_b_x, out_b_y, output ready);
endinterface

interface kbt_cfg_if import kbt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/box_center_kalman_tracker.sv
// Top level of the box center Kalman tracker: sequencer, memories and MAC unit.
//
//  Channel  Role    Word
//  in_ch    sink    one box: corner_a_x, corner_a_y, corner_b_x, corner_b_y (pixels)
//  out_ch   source  rebuilt box: out_a_x, out_a_y, out_b_x, out_b_y (Q16.16)
//  cfg_ch   sink    register write: index, data
//
// Each box runs from acceptance to the result word through the single multiply-accumulate
// unit, which reads, multiplies and accumulates each term in turn from the registered
// read of the state and work memories, and through the bit-serial divider, which forms
// each of the eight gain entries. An entry that saturates or has a zero determinant
// finishes without the bit-serial iteration.
// After reset the estimate and covariance read as their reset values through valid
// bits; no clearing pass is needed. A finished word waits in the output register
// while the next box is accepted; a stalled output holds only the final load.
`default_nettype none

module box_center_kalman_tracker import kbt_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    kbt_in_if.sink    in_ch,
    kbt_out_if.source out_ch,
    kbt_cfg_if.sink   cfg_ch
);

    // Configuration registers.
    logic [NOISE_W-1:0]       pn_reg;
    logic [NOISE_W-1:0]       mn_reg;
    logic signed [DATA_W-1:0] sx_reg;
    logic signed [DATA_W-1:0] sy_reg;

    // Sequencer.
    kbt_state_t state_reg, state_next;
    logic [4:0] elem_reg, elem_next;
    logic [2:0] sub_reg, sub_next;
    logic [1:0] ph_reg, ph_next;

    kbt_uop_t uop;
    logic     run;
    logic     is_wb;
    logic     elem_last;
    logic     in_fire;
    logic     cfg_fire;
    logic     out_load;

    // Memories.
    logic [DATA_W-1:0]        st_mem [ST_DEPTH];
    logic [DATA_W-1:0]        wk_mem [WK_DEPTH];
    logic [ST_DEPTH-1:0]      st_vld_reg;
    logic [DATA_W-1:0]        st_rd_reg;
    logic [DATA_W-1:0]        wk_rd_reg;
    logic                     rd_wk_reg;
    logic                     rd_en;
    logic                     st_we;
    logic [MEM_AW-1:0]        st_waddr;
    logic [DATA_W-1:0]        st_wdata;
    logic                     wk_we;
    logic [MEM_AW-1:0]        wk_waddr;
    logic [DATA_W-1:0]        wk_wdata;
    logic signed [DATA_W-1:0] rd_data;

    // Datapath.
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DATA_W-1:0] opa_reg;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  det_reg;
    logic signed [DATA_W-1:0] sat_acc;
    logic signed [DATA_W-1:0] xh_reg [4];
    logic signed [DATA_W-1:0] s00_reg, s01_reg, s10_reg, s11_reg;
    logic signed [DATA_W-1:0] y0_reg, y1_reg;
    logic signed [DATA_W-1:0] newx_reg, newy_reg;
    logic signed [OPD_W-1:0]  src_tab [SRC_NUM];
    logic signed [OPD_W-1:0]  op_a, op_b;

    // Latched box.
    logic [PIX_W:0]   zs_x_reg, zs_y_reg;
    logic [PIX_W-1:0] hd_x_reg, hd_y_reg;

    // Output register.
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] oax_reg, oay_reg, obx_reg, oby_reg;

    kbt_div_req_t div_req;
    kbt_div_rsp_t div_rsp;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > 48'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -48'sd2147483648)
            return 32'sh8000_0000;
        else
            return v[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] st_reset_val(input logic [MEM_AW-1:0] a,
                                                      input logic [DATA_W-1:0] sx,
                                                      input logic [DATA_W-1:0] sy);
        case (a) inside
            5'd0:                     return sx;
            5'd1:                     return sy;
            5'd4, 5'd9, 5'd14, 5'd19: return ONE_Q24;
            default:                  return '0;
        endcase
    endfunction

    function automatic logic [2:0] num_subs(input kbt_state_t st);
        unique case (st)
            ST_PRED: return 3'd2;
            ST_PP:   return 3'd5;
            ST_SINV: return 3'd2;
            ST_DET:  return 3'd2;
            ST_GAIN: return 3'd2;
            ST_EST:  return 3'd3;
            ST_COV:  return 3'd5;
            default: return 3'd0;
        endcase
    endfunction

    function automatic logic [4:0] last_elem(input kbt_state_t st);
        unique case (st)
            ST_PRED: return 5'd3;
            ST_PP:   return 5'd15;
            ST_SINV: return 5'd3;
            ST_GAIN: return 5'd7;
            ST_EST:  return 5'd3;
            ST_COV:  return 5'd15;
            default: return 5'd0;
        endcase
    endfunction

    // Micro-op table: which memory word and operands each term of each element uses.
    function automatic kbt_uop_t decode(input kbt_state_t st, input logic [4:0] e,
                                        input logic [2:0] s);
        kbt_uop_t u;
        u.wmem = 1'b0;
        u.addr = '0;
        u.sa   = SRC_RD;
        u.sb   = SRC_ONE;
        u.op   = OP_NOP;
        unique case (st)
            ST_PRED:
            begin
                if (s == 3'd0)
                begin
                    u.addr = e;
                    u.op   = OP_ADD;
                end
                else if (s == 3'd1 && !e[1])
                begin
                    u.addr = e + 5'd2;
                    u.op   = OP_ADD;
                end
            end
            ST_PP:
            begin
                case (s)
                    3'd0:
                    begin
                        u.addr = {1'b0, e[3:0]} + 5'd4;
                        u.op   = OP_ADD;
                    end
                    3'd1:
                    begin
                        u.addr = {1'b0, e[3:0]} + 5'd12;
                        u.op   = e[3] ? OP_NOP : OP_ADD;
                    end
                    3'd2:
                    begin
                        u.addr = {1'b0, e[3:0]} + 5'd6;
                        u.op   = e[1] ? OP_NOP : OP_ADD;
                    end
                    3'd3:
                    begin
                        u.addr = {1'b0, e[3:0]} + 5'd14;
                        u.op   = (e[3] || e[1]) ? OP_NOP : OP_ADD;
                    end
                    3'd4:
                    begin
                        u.sa = SRC_Q;
                        u.op = (e[3:2] == e[1:0]) ? OP_ADD : OP_NOP;
                    end
                    default: ;
                endcase
            end
            ST_SINV:
            begin
                if (s == 3'd0)
                begin
                    u.wmem = 1'b1;
                    u.addr = {2'b00, e[1], 1'b0, e[0]};
                    u.op   = OP_ADD;
                end
                else if (s == 3'd1 && e[1] == e[0])
                begin
                    u.sa = SRC_R;
                    u.op = OP_ADD;
                end
            end
            ST_DET:
            begin
                if (s == 3'd0)
                begin
                    u.sa = SRC_S00;
                    u.sb = SRC_S11;
                    u.op = OP_ADD;
                end
                else if (s == 3'd1)
                begin
                    u.sa = SRC_S01;
                    u.sb = SRC_S10;
                    u.op = OP_SUB;
                end
            end
            ST_GAIN:
            begin
                u.wmem = 1'b1;
                if (s == 3'd0)
                begin
                    u.addr = {1'b0, e[2:1], 2'b00};
                    u.sb   = e[0] ? SRC_NS01 : SRC_S11;
                    u.op   = OP_ADD;
                end
                else if (s == 3'd1)
                begin
                    u.addr = {1'b0, e[2:1], 2'b01};
                    u.sb   = e[0] ? SRC_S00 : SRC_NS10;
                    u.op   = OP_ADD;
                end
            end
            ST_EST:
            begin
                u.wmem = 1'b1;
                case (s)
                    3'd0:
                    begin
                        u.sa = SRC_XH;
                        u.op = OP_ADD;
                    end
                    3'd1:
                    begin
                        u.addr = {2'b10, e[1:0], 1'b0};
                        u.sb   = SRC_Y0;
                        u.op   = OP_ADD;
                    end
                    3'd2:
                    begin
                        u.addr = {2'b10, e[1:0], 1'b1};
                        u.sb   = SRC_Y1;
                        u.op   = OP_ADD;
                    end
                    default: ;
                endcase
            end
            ST_COV:
            begin
                u.wmem = 1'b1;
                case (s)
                    3'd0:
                    begin
                        u.addr = {1'b0, e[3:0]};
                        u.op   = OP_ADD;
                    end
                    3'd1:
                    begin
                        u.addr = {2'b10, e[3:2], 1'b0};
                        u.op   = OP_LOAD;
                    end
                    3'd2:
                    begin
                        u.addr = {3'b000, e[1:0]};
                        u.sa   = SRC_OPA;
                        u.sb   = SRC_RD;
                        u.op   = OP_SUB;
                    end
                    3'd3:
                    begin
                        u.addr = {2'b10, e[3:2], 1'b1};
                        u.op   = OP_LOAD;
                    end
                    3'd4:
                    begin
                        u.addr = {3'b001, e[1:0]};
                        u.sa   = SRC_OPA;
                        u.sb   = SRC_RD;
                        u.op   = OP_SUB;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return u;
    endfunction

    // Handshakes and sequencer decode.
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign cfg_fire  = cfg_ch.valid && cfg_ch.ready;
    assign uop       = decode(state_reg, elem_reg, sub_reg);
    assign is_wb     = (sub_reg == num_subs(state_reg));
    assign elem_last = (elem_reg == last_elem(state_reg));
    assign run       = (state_reg != ST_IDLE) && (state_reg != ST_DIV) &&
                       (state_reg != ST_OUT);
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);
    assign rd_en     = run && !is_wb && (uop.op != OP_NOP) && (ph_reg == 2'd0);

    // Next state and counters.
    always_comb
    begin
        state_next = state_reg;
        elem_next  = elem_reg;
        sub_next   = sub_reg;
        ph_next    = ph_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_PRED;
                    elem_next  = '0;
                    sub_next   = '0;
                    ph_next    = '0;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (elem_reg == last_elem(ST_GAIN))
                    begin
                        state_next = ST_EST;
                        elem_next  = '0;
                    end
                    else
                    begin
                        state_next = ST_GAIN;
                        elem_next  = elem_reg + 5'd1;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            ST_PRED, ST_PP, ST_SINV, ST_DET, ST_GAIN, ST_EST, ST_COV:
            begin
                if (is_wb)
                begin
                    sub_next = '0;
                    ph_next  = '0;
                    if (state_reg == ST_GAIN)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (elem_last)
                    begin
                        elem_next = '0;
                        unique case (state_reg)
                            ST_PRED: state_next = ST_PP;
                            ST_PP:   state_next = ST_SINV;
                            ST_SINV: state_next = ST_DET;
                            ST_DET:  state_next = ST_GAIN;
                            ST_EST:  state_next = ST_COV;
                            ST_COV:  state_next = ST_OUT;
                            default: state_next = ST_IDLE;
                        endcase
                    end
                    else
                    begin
                        elem_next = elem_reg + 5'd1;
                    end
                end
                else if (uop.op == OP_NOP || ph_reg == 2'd2)
                begin
                    sub_next = sub_reg + 3'd1;
                    ph_next  = '0;
                end
                else
                begin
                    ph_next = ph_reg + 2'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory writes, divider start and ready lines.
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = sat_acc;
        wk_we    = 1'b0;
        wk_waddr = elem_reg;
        wk_wdata = sat_acc;
        div_req.start = 1'b0;
        div_req.num   = acc_reg;
        div_req.den   = det_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_fire && (cfg_ch.index == CFG_START_X || cfg_ch.index == CFG_START_Y))
                begin
                    st_we    = 1'b1;
                    st_waddr = (cfg_ch.index == CFG_START_X) ? 5'd0 : 5'd1;
                    st_wdata = cfg_ch.data;
                end
            end
            ST_PP:
            begin
                wk_we = is_wb;
            end
            ST_GAIN:
            begin
                div_req.start = is_wb;
            end
            ST_DIV:
            begin
                wk_we    = div_rsp.done;
                wk_waddr = {2'b10, elem_reg[2:0]};
                wk_wdata = div_rsp.quot;
            end
            ST_EST:
            begin
                st_we    = is_wb;
                st_waddr = elem_reg;
            end
            ST_COV:
            begin
                st_we    = is_wb;
                st_waddr = elem_reg + 5'd4;
            end
            default: ;
        endcase
    end

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign cfg_ch.ready = (state_reg == ST_IDLE);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            elem_reg      <= '0;
            sub_reg       <= '0;
            ph_reg        <= '0;
            pn_reg        <= PROCESS_NOISE_RST;
            mn_reg        <= MEASURE_NOISE_RST;
            sx_reg        <= START_RST;
            sy_reg        <= START_RST;
            st_vld_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            elem_reg  <= elem_next;
            sub_reg   <= sub_next;
            ph_reg    <= ph_next;
            if (cfg_fire)
            begin
                unique case (cfg_ch.index)
                    CFG_PROCESS_NOISE: pn_reg <= cfg_ch.data[NOISE_W-1:0];
                    CFG_MEASURE_NOISE: mn_reg <= cfg_ch.data[NOISE_W-1:0];
                    CFG_START_X:       sx_reg <= cfg_ch.data;
                    CFG_START_Y:       sy_reg <= cfg_ch.data;
                    default: ;
                endcase
            end
            if (st_we)
                st_vld_reg[st_waddr] <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // State memory: estimate then covariance, registered read.
    always_ff @(posedge clk)
    begin
        if (st_we)
            st_mem[st_waddr] <= st_wdata;
        if (rd_en)
            st_rd_reg <= st_vld_reg[uop.addr] ? st_mem[uop.addr]
                                              : st_reset_val(uop.addr, sx_reg, sy_reg);
    end

    // Work memory: predicted covariance then gain, registered read.
    always_ff @(posedge clk)
    begin
        if (wk_we)
            wk_mem[wk_waddr] <= wk_wdata;
        if (rd_en)
        begin
            wk_rd_reg <= wk_mem[uop.addr];
            rd_wk_reg <= uop.wmem;
        end
    end

    assign rd_data = rd_wk_reg ? wk_rd_reg : st_rd_reg;

    // Operand selection for the multiplier.
    always_comb
    begin
        src_tab[SRC_RD]   = OPD_W'(rd_data);
        src_tab[SRC_OPA]  = OPD_W'(opa_reg);
        src_tab[SRC_ONE]  = OPD_W'(ONE_Q24);
        src_tab[SRC_Q]    = {2'b00, pn_reg};
        src_tab[SRC_R]    = {2'b00, mn_reg};
        src_tab[SRC_S00]  = OPD_W'(s00_reg);
        src_tab[SRC_S01]  = OPD_W'(s01_reg);
        src_tab[SRC_S10]  = OPD_W'(s10_reg);
        src_tab[SRC_S11]  = OPD_W'(s11_reg);
        src_tab[SRC_NS01] = -OPD_W'(s01_reg);
        src_tab[SRC_NS10] = -OPD_W'(s10_reg);
        src_tab[SRC_Y0]   = OPD_W'(y0_reg);
        src_tab[SRC_Y1]   = OPD_W'(y1_reg);
        src_tab[SRC_XH]   = OPD_W'(xh_reg[elem_reg[1:0]]);
        op_a = src_tab[uop.sa];
        op_b = src_tab[uop.sb];
    end

    assign term    = ACC_W'(prod_reg >>> Q_SHIFT);
    assign sat_acc = sat32(acc_reg);

    // Multiply-accumulate datapath and element results.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            zs_x_reg <= {1'b0, in_ch.corner_a_x} + {1'b0, in_ch.corner_b_x};
            zs_y_reg <= {1'b0, in_ch.corner_a_y} + {1'b0, in_ch.corner_b_y};
            hd_x_reg <= (in_ch.corner_a_x > in_ch.corner_b_x)
                        ? in_ch.corner_a_x - in_ch.corner_b_x
                        : in_ch.corner_b_x - in_ch.corner_a_x;
            hd_y_reg <= (in_ch.corner_a_y > in_ch.corner_b_y)
                        ? in_ch.corner_a_y - in_ch.corner_b_y
                        : in_ch.corner_b_y - in_ch.corner_a_y;
            acc_reg  <= '0;
        end
        if (run && !is_wb && uop.op != OP_NOP)
        begin
            if (ph_reg == 2'd1)
            begin
                if (uop.op == OP_LOAD)
                    opa_reg <= rd_data;
                else
                    prod_reg <= op_a * op_b;
            end
            if (ph_reg == 2'd2)
            begin
                case (uop.op)
                    OP_ADD:  acc_reg <= acc_reg + term;
                    OP_SUB:  acc_reg <= acc_reg - term;
                    default: ;
                endcase
            end
        end
        if (run && is_wb)
        begin
            acc_reg <= '0;
            case (state_reg)
                ST_PRED: xh_reg[elem_reg[1:0]] <= sat_acc;
                ST_SINV:
                begin
                    case (elem_reg[1:0])
                        2'd0:    s00_reg <= sat_acc;
                        2'd1:    s01_reg <= sat_acc;
                        2'd2:    s10_reg <= sat_acc;
                        default: s11_reg <= sat_acc;
                    endcase
                end
                ST_DET:  det_reg <= acc_reg;
                ST_EST:
                begin
                    if (elem_reg[1:0] == 2'd0)
                        newx_reg <= sat_acc;
                    if (elem_reg[1:0] == 2'd1)
                        newy_reg <= sat_acc;
                end
                default: ;
            endcase
        end
        // Innovation against the predicted position.
        if (state_reg == ST_SINV)
        begin
            y0_reg <= sat32(ACC_W'($signed({1'b0, zs_x_reg, 15'b0})) - ACC_W'(xh_reg[0]));
            y1_reg <= sat32(ACC_W'($signed({1'b0, zs_y_reg, 15'b0})) - ACC_W'(xh_reg[1]));
        end
    end

    // Output word: corners rebuilt around the filtered center.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            oax_reg <= sat32(ACC_W'(newx_reg) + ACC_W'($signed({1'b0, hd_x_reg, 15'b0})));
            oay_reg <= sat32(ACC_W'(newy_reg) + ACC_W'($signed({1'b0, hd_y_reg, 15'b0})));
            obx_reg <= sat32(ACC_W'(newx_reg) - ACC_W'($signed({1'b0, hd_x_reg, 15'b0})));
            oby_reg <= sat32(ACC_W'(newy_reg) - ACC_W'($signed({1'b0, hd_y_reg, 15'b0})));
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.out_a_x = oax_reg;
    assign out_ch.out_a_y = oay_reg;
    assign out_ch.out_b_x = obx_reg;
    assign out_ch.out_b_y = oby_reg;

    kbt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_PRED)
        else $error("accepted box did not start the predict step");
    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider result arrived outside the gain step");
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("output word appeared without a finished step");
    a_no_mem_clash: assert property (@(posedge clk) disable iff (!rst_n)
        st_we && rd_en |-> uop.wmem)
        else $error("state memory written while a term reads it");
`endif

endmodule

`default_nettype wire

// File: rtl/kbt_div.sv
// Bit-serial signed divider that forms a Q8.24 gain entry with saturation.
`default_nettype none

module kbt_div import kbt_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  kbt_div_req_t req,
    output kbt_div_rsp_t rsp
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [4:0]              cnt_reg;
    logic                    neg_reg;
    logic [ACC_W-1:0]        dm_reg;
    logic [ACC_W-1:0]        rem_reg;
    logic [QUOT_W-1:0]       bits_reg;
    logic [QUOT_W-2:0]       quot_reg;
    logic signed [DATA_W-1:0] res_reg;

    logic [ACC_W-1:0]   un;
    logic [ACC_W-1:0]   ud;
    logic               ovf;
    logic [ACC_W:0]     trial;
    logic               qbit;
    logic [ACC_W-1:0]   rem_next;
    logic [QUOT_W-1:0]  q_fin;

    // Magnitudes and the range check of the quotient.
    always_comb
    begin
        un    = req.num[ACC_W-1] ? ACC_W'(-req.num) : ACC_W'(req.num);
        ud    = req.den[ACC_W-1] ? ACC_W'(-req.den) : ACC_W'(req.den);
        ovf   = {7'b0, un} >= {ud, 7'b0};
        trial = {rem_reg, bits_reg[QUOT_W-1]};
        qbit  = trial >= {1'b0, dm_reg};
        rem_next = qbit ? ACC_W'(trial - {1'b0, dm_reg}) : trial[ACC_W-1:0];
        q_fin = {quot_reg, qbit};
    end

    // Iteration control: one quotient bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                if (ud == '0 || ovf)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 5'(QUOT_W - 1);
                end
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    // Remainder, quotient and result.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg  <= req.num[ACC_W-1] ^ req.den[ACC_W-1];
            dm_reg   <= ud;
            rem_reg  <= un >> 7;
            bits_reg <= {un[6:0], 24'b0};
            quot_reg <= '0;
            if (ud == '0)
                res_reg <= '0;
            else
                res_reg <= (req.num[ACC_W-1] ^ req.den[ACC_W-1]) ? 32'sh8000_0000
                                                                  : 32'sh7FFF_FFFF;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            bits_reg <= bits_reg << 1;
            quot_reg <= q_fin[QUOT_W-2:0];
            if (cnt_reg == '0)
                res_reg <= neg_reg ? -{1'b0, q_fin} : {1'b0, q_fin};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = res_reg;

`ifndef SYNTHESIS
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg == '0 && !req.start |=> done_reg && !busy_reg)
        else $error("divider did not finish after its last bit");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("divider restarted while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg || $past(req.start))
        else $error("divider done held without a new request");
`endif

endmodule

`default_nettype wire
